[rtl/core/acmm_pkg.sv]
// Shared types and constants for the audio channel matrix mixer.
`default_nettype none

package acmm_pkg;

  localparam int SAMPLE_W   = 16;  // audio sample and gain width
  localparam int N_FIELDS   = 4;   // source / destination fields per frame
  localparam int CNT_W      = 3;   // channel count register width
  localparam int CFG_DATA_W = 64;  // config data bus width
  localparam int CFG_ADDR_W = 6;   // byte address, 8 bytes per register
  localparam int CFG_IDX_W  = 3;   // register index taken from paddr

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SRC_CHANNELS = 3'd0,
    REG_DST_CHANNELS = 3'd1,
    REG_COEF_ROW_0   = 3'd2,
    REG_COEF_ROW_1   = 3'd3,
    REG_COEF_ROW_2   = 3'd4,
    REG_COEF_ROW_3   = 3'd5
  } cfg_reg_t;

  // Per-destination control handed from the top level to each lane.
  typedef struct packed {
    logic [CNT_W-1:0] src_cnt;  // sources summed, already clamped
    logic             active;   // lane is below the destination count
  } lane_ctrl_t;

endpackage

`default_nettype wire

[rtl/core/audio_channel_matrix_mixer_unit.sv]
// Top level of the audio channel matrix mixer: config registers, pipeline, lanes.
//
//  channel | handshake                   | payload
//  --------+-----------------------------+-------------------------------------
//  in      | start / busy (busy tied low)| in_src_sample_0..3, in_old_dst_0..3
//  out     | out_valid, one-cycle strobe | out_mixed_0..3
//  cfg     | APB psel/penable/pwrite     | paddr (8 bytes per reg), pwdata/prdata
//
// One frame beat is taken every cycle; busy never rises. Stages: input reg,
// product reg (one 16x16 multiplier per gain), then truncating sum chain and
// saturation into the result reg. The valid bit walks vld_r[0], [1], [2] with
// the beat and drives out_valid from the result reg stage.
// Synchronous active-low reset clears the valid pipe and loads one source,
// one destination, zero gains. The receiver cannot stall; nothing backs up.
`default_nettype none

module audio_channel_matrix_mixer_unit
  import acmm_pkg::*;
#(
  parameter int MAX_SRC_CHANNELS = 4,
  parameter int MAX_DST_CHANNELS = 4,
  parameter int COEF_FRAC_BITS   = 14
) (
  input  wire                         clk,
  input  wire                         rst_n,
  // frame input
  input  wire                         start,
  output logic                        busy,
  input  wire  signed [SAMPLE_W-1:0]  in_src_sample_0,
  input  wire  signed [SAMPLE_W-1:0]  in_src_sample_1,
  input  wire  signed [SAMPLE_W-1:0]  in_src_sample_2,
  input  wire  signed [SAMPLE_W-1:0]  in_src_sample_3,
  input  wire  signed [SAMPLE_W-1:0]  in_old_dst_0,
  input  wire  signed [SAMPLE_W-1:0]  in_old_dst_1,
  input  wire  signed [SAMPLE_W-1:0]  in_old_dst_2,
  input  wire  signed [SAMPLE_W-1:0]  in_old_dst_3,
  // mixed output
  output logic                        out_valid,
  output logic signed [SAMPLE_W-1:0]  out_mixed_0,
  output logic signed [SAMPLE_W-1:0]  out_mixed_1,
  output logic signed [SAMPLE_W-1:0]  out_mixed_2,
  output logic signed [SAMPLE_W-1:0]  out_mixed_3,
  // config port
  input  wire                         psel,
  input  wire                         penable,
  input  wire                         pwrite,
  input  wire  [CFG_ADDR_W-1:0]       paddr,
  input  wire  [CFG_DATA_W-1:0]       pwdata,
  output logic [CFG_DATA_W-1:0]       prdata,
  output logic                        pready
);

  // lanes actually built: capped by the four frame fields
  localparam int NSRC = (MAX_SRC_CHANNELS < N_FIELDS) ? MAX_SRC_CHANNELS : N_FIELDS;
  localparam int NDST = (MAX_DST_CHANNELS < N_FIELDS) ? MAX_DST_CHANNELS : N_FIELDS;

  // ---------------- config registers ----------------
  logic [CNT_W-1:0]      src_ch_r, src_ch_nxt;
  logic [CNT_W-1:0]      dst_ch_r, dst_ch_nxt;
  logic [CFG_DATA_W-1:0] coef_r   [N_FIELDS];
  logic [CFG_DATA_W-1:0] coef_nxt [N_FIELDS];
  logic                  cfg_wr;
  cfg_reg_t              cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = cfg_reg_t'(paddr[CFG_ADDR_W-1 -: CFG_IDX_W]);

  always_comb begin
    src_ch_nxt = src_ch_r;
    dst_ch_nxt = dst_ch_r;
    coef_nxt   = coef_r;
    if (cfg_wr) begin
      case (cfg_idx)
        REG_SRC_CHANNELS: src_ch_nxt  = pwdata[CNT_W-1:0];
        REG_DST_CHANNELS: dst_ch_nxt  = pwdata[CNT_W-1:0];
        REG_COEF_ROW_0:   coef_nxt[0] = pwdata;
        REG_COEF_ROW_1:   coef_nxt[1] = pwdata;
        REG_COEF_ROW_2:   coef_nxt[2] = pwdata;
        REG_COEF_ROW_3:   coef_nxt[3] = pwdata;
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_ch_r <= CNT_W'(1);
      dst_ch_r <= CNT_W'(1);
      for (int r = 0; r < N_FIELDS; r++) begin
        coef_r[r] <= '0;
      end
    end else begin
      src_ch_r <= src_ch_nxt;
      dst_ch_r <= dst_ch_nxt;
      coef_r   <= coef_nxt;
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_SRC_CHANNELS: prdata = {{(CFG_DATA_W-CNT_W){1'b0}}, src_ch_r};
      REG_DST_CHANNELS: prdata = {{(CFG_DATA_W-CNT_W){1'b0}}, dst_ch_r};
      REG_COEF_ROW_0:   prdata = coef_r[0];
      REG_COEF_ROW_1:   prdata = coef_r[1];
      REG_COEF_ROW_2:   prdata = coef_r[2];
      REG_COEF_ROW_3:   prdata = coef_r[3];
      default:          prdata = '0;
    endcase
  end

  // clamp channel counts to the lanes present
  logic [CNT_W-1:0] src_cnt, dst_cnt;
  assign src_cnt = (src_ch_r > CNT_W'(NSRC)) ? CNT_W'(NSRC) : src_ch_r;
  assign dst_cnt = (dst_ch_r > CNT_W'(NDST)) ? CNT_W'(NDST) : dst_ch_r;

  // ---------------- frame pipeline ----------------
  // vld_r[0]: input reg, [1]: products, [2]: result
  logic [2:0] vld_r, vld_nxt;
  logic [N_FIELDS-1:0][SAMPLE_W-1:0] sample_r, old_r;

  assign busy    = 1'b0;
  assign vld_nxt = {vld_r[1:0], start & ~busy};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // payload regs load every cycle; out_valid marks the real beats
  always_ff @(posedge clk) begin
    sample_r <= {in_src_sample_3, in_src_sample_2, in_src_sample_1, in_src_sample_0};
    old_r    <= {in_old_dst_3, in_old_dst_2, in_old_dst_1, in_old_dst_0};
  end

  assign out_valid = vld_r[2];

  logic [N_FIELDS-1:0][SAMPLE_W-1:0] mixed;

  for (genvar r = 0; r < N_FIELDS; r++) begin : g_dst
    if (r < NDST) begin : g_lane
      lane_ctrl_t ctl;
      assign ctl.src_cnt = src_cnt;
      assign ctl.active  = CNT_W'(r) < dst_cnt;

      acmm_dst_lane #(
        .NSRC (NSRC),
        .FRAC (COEF_FRAC_BITS)
      ) u_lane (
        .clk       (clk),
        .ctl       (ctl),
        .samples_i (sample_r),
        .coef_i    (coef_r[r]),
        .old_i     (old_r[r]),
        .mixed_o   (mixed[r])
      );
    end else begin : g_off
      assign mixed[r] = '0;  // destination beyond the built lanes
    end
  end

  assign out_mixed_0 = mixed[0];
  assign out_mixed_1 = mixed[1];
  assign out_mixed_2 = mixed[2];
  assign out_mixed_3 = mixed[3];

endmodule

`default_nettype wire

[rtl/core/acmm_dst_lane.sv]
// One destination channel: gain products, truncating sum chain, saturation.
`default_nettype none

module acmm_dst_lane
  import acmm_pkg::*;
#(
  parameter int NSRC = 4,
  parameter int FRAC = 14
) (
  input  wire                                   clk,
  input  wire  lane_ctrl_t                      ctl,
  input  wire  [N_FIELDS-1:0][SAMPLE_W-1:0]     samples_i,
  input  wire  [N_FIELDS*SAMPLE_W-1:0]          coef_i,
  input  wire  [SAMPLE_W-1:0]                   old_i,
  output logic [SAMPLE_W-1:0]                   mixed_o
);

  localparam int PROD_W = 2 * SAMPLE_W;
  localparam int ACC_W  = PROD_W - FRAC + $clog2(NSRC + 1) + 1;
  localparam int TOT_W  = ACC_W + FRAC + 1;
  localparam int SUM_W  = ACC_W + 1;

  logic signed [PROD_W-1:0] prod_r   [NSRC];
  logic signed [PROD_W-1:0] prod_nxt [NSRC];
  logic        [SAMPLE_W-1:0] old_r;
  logic        [SAMPLE_W-1:0] mixed_r, mixed_nxt;
  logic signed [ACC_W-1:0]  acc;
  logic signed [SUM_W-1:0]  sum;
  logic                     sat_hi, sat_lo;

  // stage 1: all products in parallel
  always_comb begin
    for (int j = 0; j < NSRC; j++) begin
      prod_nxt[j] = $signed(samples_i[j]) * $signed(coef_i[j*SAMPLE_W +: SAMPLE_W]);
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    old_r  <= old_i;
  end

  // stage 2: acc = trunc((acc * 2^F + p) / 2^F), one step per source
  always_comb begin : sum_chain
    logic signed [TOT_W-1:0] tot;
    logic                    bump;
    acc = '0;
    for (int j = 0; j < NSRC; j++) begin
      tot  = ({{(TOT_W-ACC_W){acc[ACC_W-1]}}, acc} <<< FRAC)
           + {{(TOT_W-PROD_W){prod_r[j][PROD_W-1]}}, prod_r[j]};
      // floor shift, then step toward zero on a negative inexact value
      bump = tot[TOT_W-1] & (|tot[FRAC-1:0]);
      if (CNT_W'(j) < ctl.src_cnt) begin
        acc = tot[ACC_W+FRAC-1:FRAC] + ACC_W'(bump);
      end
    end
  end

  always_comb begin
    sum    = {acc[ACC_W-1], acc}
           + {{(SUM_W-SAMPLE_W){old_r[SAMPLE_W-1]}}, old_r};
    sat_hi = !sum[SUM_W-1] && (|sum[SUM_W-2:SAMPLE_W-1]);
    sat_lo =  sum[SUM_W-1] && !(&sum[SUM_W-2:SAMPLE_W-1]);
    if (!ctl.active) begin
      mixed_nxt = '0;
    end else if (sat_hi) begin
      mixed_nxt = {1'b0, {(SAMPLE_W-1){1'b1}}};
    end else if (sat_lo) begin
      mixed_nxt = {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      mixed_nxt = sum[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    mixed_r <= mixed_nxt;
  end

  assign mixed_o = mixed_r;

endmodule

`default_nettype wire

[rtl/core/acmm_checker.sv]
// Port-level checks for the audio channel matrix mixer, bound to the top level.
`default_nettype none

module acmm_checker
  import acmm_pkg::*;
(
  input wire                  clk,
  input wire                  rst_n,
  input wire                  start,
  input wire                  busy,
  input wire                  out_valid,
  input wire                  psel,
  input wire                  penable,
  input wire                  pwrite,
  input wire                  pready,
  input wire [CFG_ADDR_W-1:0] paddr,
  input wire [CFG_DATA_W-1:0] pwdata,
  input wire [CFG_DATA_W-1:0] prdata
);

  // every accepted frame beat yields exactly one result on out_valid
  a_beat_to_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##3 out_valid)
    else $error("accepted beat produced no result");

  a_result_has_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 3))
    else $error("result strobe without an accepted beat");

  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !busy)
    else $error("busy raised");

  // a gain row written reads back unchanged
  a_coef_readback: assert property (@(posedge clk) disable iff (!rst_n)
    (psel && penable && pwrite && pready &&
     (paddr[CFG_ADDR_W-1 -: CFG_IDX_W] == REG_COEF_ROW_0 ||
      paddr[CFG_ADDR_W-1 -: CFG_IDX_W] == REG_COEF_ROW_1 ||
      paddr[CFG_ADDR_W-1 -: CFG_IDX_W] == REG_COEF_ROW_2 ||
      paddr[CFG_ADDR_W-1 -: CFG_IDX_W] == REG_COEF_ROW_3))
    ##1 (paddr == $past(paddr)) |-> (prdata == $past(pwdata)))
    else $error("gain row readback mismatch");

endmodule

bind audio_channel_matrix_mixer_unit acmm_checker u_acmm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .psel      (psel),
  .penable   (penable),
  .pwrite    (pwrite),
  .pready    (pready),
  .paddr     (paddr),
  .pwdata    (pwdata),
  .prdata    (prdata)
);

`default_nettype wire

[test/tb_top.sv]
// Self-checking testbench for the audio channel matrix mixer unit.
`timescale 1ns / 100ps

module tb_top;
  import acmm_pkg::*;

  // Block configuration under test
  localparam int  MAX_SRC       = 4;
  localparam int  MAX_DST       = 4;
  localparam int  FRAC_BITS     = 14;
  localparam int  LANES         = N_FIELDS;
  localparam longint GAIN_ONE   = longint'(1) << FRAC_BITS;
  localparam longint SAMPLE_MAX = 32767;
  localparam longint SAMPLE_MIN = -32768;

  // Register map: 8 bytes per register, index in paddr[5:3]
  localparam int REG_BYTE_SHIFT = 3;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;  // unmapped, writes dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

  // Run shape
  localparam int CLK_HALF_NS    = 10;
  localparam int RESET_CYCLES   = 7;
  localparam int SETTLE_CYCLES  = 8;        // pipe is three deep, keep a margin
  localparam int RAND_SETTINGS  = 12;
  localparam int RAND_FRAMES    = 104;      // per setting, ~1250 frames overall
  localparam int TIMEOUT_NS     = 4_000_000;

  // Gain codes in Q2.14
  localparam logic [SAMPLE_W-1:0] GAIN_UNITY   = 16'h4000;
  localparam logic [SAMPLE_W-1:0] GAIN_NEG_ONE = 16'hC000;
  localparam logic [SAMPLE_W-1:0] GAIN_NEG_TWO = 16'h8000;
  localparam logic [SAMPLE_W-1:0] GAIN_TOP     = 16'h7FFF;
  localparam logic [SAMPLE_W-1:0] GAIN_HALF    = 16'h2000;

  typedef logic [LANES-1:0][SAMPLE_W-1:0] lanes_t;

  typedef struct packed {
    lanes_t src;  // source samples
    lanes_t old;  // destination samples mixed into
  } frame_t;

  // ---------------------------------------------------------------------------
  // Clock, reset and DUT signals; every input starts at a known value
  // ---------------------------------------------------------------------------
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                       start   = 1'b0;
  logic                       busy;
  logic [SAMPLE_W-1:0]        in_src_sample_0 = '0;
  logic [SAMPLE_W-1:0]        in_src_sample_1 = '0;
  logic [SAMPLE_W-1:0]        in_src_sample_2 = '0;
  logic [SAMPLE_W-1:0]        in_src_sample_3 = '0;
  logic [SAMPLE_W-1:0]        in_old_dst_0 = '0;
  logic [SAMPLE_W-1:0]        in_old_dst_1 = '0;
  logic [SAMPLE_W-1:0]        in_old_dst_2 = '0;
  logic [SAMPLE_W-1:0]        in_old_dst_3 = '0;
  logic                       out_valid;
  logic [SAMPLE_W-1:0]        out_mixed_0;
  logic [SAMPLE_W-1:0]        out_mixed_1;
  logic [SAMPLE_W-1:0]        out_mixed_2;
  logic [SAMPLE_W-1:0]        out_mixed_3;
  logic                       psel    = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0]      paddr   = '0;
  logic [CFG_DATA_W-1:0]      pwdata  = '0;
  logic [CFG_DATA_W-1:0]      prdata;
  logic                       pready;

  always #(CLK_HALF_NS) clk = ~clk;

  audio_channel_matrix_mixer_unit #(
    .MAX_SRC_CHANNELS (MAX_SRC),
    .MAX_DST_CHANNELS (MAX_DST),
    .COEF_FRAC_BITS   (FRAC_BITS)
  ) i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_src_sample_0 (in_src_sample_0),
    .in_src_sample_1 (in_src_sample_1),
    .in_src_sample_2 (in_src_sample_2),
    .in_src_sample_3 (in_src_sample_3),
    .in_old_dst_0    (in_old_dst_0),
    .in_old_dst_1    (in_old_dst_1),
    .in_old_dst_2    (in_old_dst_2),
    .in_old_dst_3    (in_old_dst_3),
    .out_valid       (out_valid),
    .out_mixed_0     (out_mixed_0),
    .out_mixed_1     (out_mixed_1),
    .out_mixed_2     (out_mixed_2),
    .out_mixed_3     (out_mixed_3),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  // ---------------------------------------------------------------------------
  // Mixer model state: a private copy of the registers, reset values loaded
  // ---------------------------------------------------------------------------
  logic [CNT_W-1:0]      src_count = 3'd1;
  logic [CNT_W-1:0]      dst_count = 3'd1;
  logic [CFG_DATA_W-1:0] gain_row [LANES] = '{default: '0};

  frame_t frames_to_send [$];   // filled by the sequencer, drained by the driver
  lanes_t mixes_expected [$];   // one predicted output beat per accepted frame

  int send_idle_pct  = 10;
  int frames_sent    = 0;
  int beats_checked  = 0;
  int clipped_lanes  = 0;
  int settings_used  = 0;
  int mismatches     = 0;

  // Expected output beat for one frame under the current register copy.
  // The running sum is cut back to whole samples after every gain term,
  // truncating toward zero, before the old destination sample is added.
  function automatic lanes_t mix_frame(frame_t f);
    int     n_src;
    int     n_dst;
    longint acc;
    longint term;
    lanes_t res;
    n_src = (src_count > MAX_SRC) ? MAX_SRC : int'(src_count);
    n_dst = (dst_count > MAX_DST) ? MAX_DST : int'(dst_count);
    res = '0;
    for (int r = 0; r < LANES; r++) begin
      if (r < n_dst) begin
        acc = 0;
        for (int j = 0; j < n_src; j++) begin
          term = longint'($signed(f.src[j])) *
                 longint'($signed(gain_row[r][SAMPLE_W*j +: SAMPLE_W]));
          acc = (acc * GAIN_ONE + term) / GAIN_ONE;
        end
        acc += longint'($signed(f.old[r]));
        if (acc > SAMPLE_MAX) begin
          acc = SAMPLE_MAX;
          clipped_lanes++;
        end else if (acc < SAMPLE_MIN) begin
          acc = SAMPLE_MIN;
          clipped_lanes++;
        end
        res[r] = acc[SAMPLE_W-1:0];
      end
    end
    return res;
  endfunction

  task automatic flag_mismatch(input string what, input int lane,
                               input logic [SAMPLE_W-1:0] got,
                               input logic [SAMPLE_W-1:0] want);
    $display("%0t: mismatch beat %0d %s lane %0d: got %0d, want %0d", $time,
             beats_checked, what, lane, $signed(got), $signed(want));
    mismatches++;
  endtask

  // ---------------------------------------------------------------------------
  // Frame driver: a beat is taken at an edge with start high and busy low.
  // The prediction is made at that same edge, against the register copy.
  // ---------------------------------------------------------------------------
  frame_t drv_frame = '0;

  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        mixes_expected.insert(mixes_expected.size(), mix_frame(drv_frame));
        frames_sent++;
      end
      // Only move on once the current beat is gone (or nothing is offered)
      if (!start || !busy) begin
        if (frames_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          drv_frame = frames_to_send.pop_front();
          start           <= 1'b1;
          in_src_sample_0 <= drv_frame.src[0];
          in_src_sample_1 <= drv_frame.src[1];
          in_src_sample_2 <= drv_frame.src[2];
          in_src_sample_3 <= drv_frame.src[3];
          in_old_dst_0    <= drv_frame.old[0];
          in_old_dst_1    <= drv_frame.old[1];
          in_old_dst_2    <= drv_frame.old[2];
          in_old_dst_3    <= drv_frame.old[3];
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output monitor: out_valid is a one-cycle strobe, no back-pressure
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    lanes_t got;
    lanes_t want;
    if (rst_n && out_valid) begin
      got = {out_mixed_3, out_mixed_2, out_mixed_1, out_mixed_0};
      if (mixes_expected.size() == 0) begin
        flag_mismatch("unexpected beat", 0, got[0], '0);
      end else begin
        want = mixes_expected.pop_front();
        for (int r = 0; r < LANES; r++)
          if (got[r] !== want[r]) flag_mismatch("out_mixed", r, got[r], want[r]);
      end
      beats_checked++;
    end
  end

  // ---------------------------------------------------------------------------
  // Config port and stimulus helpers
  // ---------------------------------------------------------------------------
  // Setup cycle, then access; the write lands at the edge with pready high.
  task automatic reg_write(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_W'(idx) << REG_BYTE_SHIFT;
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_SRC_CHANNELS: src_count   = val[CNT_W-1:0];
      REG_DST_CHANNELS: dst_count   = val[CNT_W-1:0];
      REG_COEF_ROW_0:   gain_row[0] = val;
      REG_COEF_ROW_1:   gain_row[1] = val;
      REG_COEF_ROW_2:   gain_row[2] = val;
      REG_COEF_ROW_3:   gain_row[3] = val;
      default: ;  // unmapped index, ignored
    endcase
  endtask

  // Counts go in with junk in the upper bits; only [2:0] should stick.
  task automatic set_counts(input logic [CNT_W-1:0] n_src, input logic [CNT_W-1:0] n_dst);
    logic [CFG_DATA_W-1:0] val;
    val = {$urandom, $urandom};
    val[CNT_W-1:0] = n_src;
    reg_write(REG_SRC_CHANNELS, val);
    val = {$urandom, $urandom};
    val[CNT_W-1:0] = n_dst;
    reg_write(REG_DST_CHANNELS, val);
    settings_used++;
  endtask

  task automatic set_gains(input lanes_t g0, input lanes_t g1,
                           input lanes_t g2, input lanes_t g3);
    reg_write(REG_COEF_ROW_0, g0);
    reg_write(REG_COEF_ROW_1, g1);
    reg_write(REG_COEF_ROW_2, g2);
    reg_write(REG_COEF_ROW_3, g3);
  endtask

  task automatic queue_frame(input lanes_t src, input lanes_t old);
    frame_t f;
    f.src = src;
    f.old = old;
    frames_to_send.insert(frames_to_send.size(), f);
  endtask

  // Wait until every queued frame went in and its beat came back.
  task automatic drain();
    while (frames_to_send.size() != 0 || start) @(posedge clk);
    while (mixes_expected.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Samples lean on the rails and small signed values (truncation sign cases)
  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(7))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return SAMPLE_W'($urandom_range(31)) - 16'd16;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_gain();
    case ($urandom_range(9))
      0:       return GAIN_UNITY;
      1:       return GAIN_NEG_ONE;
      2:       return GAIN_NEG_TWO;
      3:       return GAIN_TOP;
      4:       return GAIN_HALF;
      5:       return SAMPLE_W'($urandom_range(15)) - 16'd8;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  function automatic lanes_t pick_lanes(input bit gains);
    lanes_t v;
    for (int i = 0; i < LANES; i++) v[i] = gains ? pick_gain() : pick_sample();
    return v;
  endfunction

  // Mostly the legal 1..4 counts, now and then 0 or a value past the limit
  function automatic logic [CNT_W-1:0] pick_count();
    if ($urandom_range(5) == 0) return CNT_W'($urandom_range(7));
    return CNT_W'($urandom_range(1, 4));
  endfunction

  initial begin
    #(TIMEOUT_NS);
    $display("timeout: run did not finish");
    $display("CHECKS FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Sequencer: directed settings first, then random settings in three idle
  // regimes (sender idles 10%, then 69%, then never).
  // ---------------------------------------------------------------------------
  initial begin
    logic [CNT_W-1:0] n_src;
    logic [CNT_W-1:0] n_dst;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Reset defaults: one source, one destination, all gains zero
    send_idle_pct = 10;
    settings_used++;
    queue_frame({4{16'h7FFF}}, {4{16'h7FFF}});
    queue_frame({4{16'h8000}}, {4{16'h8000}});
    drain();

    // Full matrix, gains at unity, -2, the top code and a mixed row
    set_counts(3'd4, 3'd4);
    set_gains({4{GAIN_UNITY}}, {4{GAIN_NEG_TWO}}, {4{GAIN_TOP}},
              {GAIN_NEG_ONE, 16'h0001, 16'hFFFF, GAIN_HALF});
    queue_frame({4{16'h7FFF}}, {4{16'h7FFF}});
    queue_frame({4{16'h8000}}, {4{16'h8000}});
    queue_frame('0, '0);
    queue_frame({16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF}, '0);
    queue_frame({4{16'h0001}}, {4{16'hFFFF}});
    // odd samples times half: truncation of negative partial sums
    queue_frame({16'hFFFB, 16'h0005, 16'hFFFD, 16'h0003}, '0);
    queue_frame({16'h7FFF, 16'h8000, 16'h0001, 16'hFFFF}, {16'h0001, 16'h8000, 16'h7FFF, 16'hFFFF});
    drain();

    // No sources summed, destination count past the limit: old samples pass
    set_counts(3'd0, 3'd7);
    queue_frame({4{16'h7FFF}}, {16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF});
    queue_frame(pick_lanes(0), pick_lanes(0));
    queue_frame(pick_lanes(0), pick_lanes(0));
    drain();

    // Source count past the limit, no destinations: all lanes zero.
    // Unmapped register indexes must not disturb anything.
    set_counts(3'd7, 3'd0);
    reg_write(REG_SPARE_6, {$urandom, $urandom});
    reg_write(REG_SPARE_7, {$urandom, $urandom});
    queue_frame({4{16'h7FFF}}, {4{16'h7FFF}});
    queue_frame(pick_lanes(0), pick_lanes(0));
    queue_frame(pick_lanes(0), pick_lanes(0));
    drain();

    // Partial matrix with random gains
    set_counts(3'd2, 3'd3);
    set_gains(pick_lanes(1), pick_lanes(1), pick_lanes(1), pick_lanes(1));
    queue_frame(pick_lanes(0), pick_lanes(0));
    queue_frame(pick_lanes(0), pick_lanes(0));
    queue_frame(pick_lanes(0), pick_lanes(0));
    drain();

    // Random settings and frames
    for (int k = 0; k < RAND_SETTINGS; k++) begin
      send_idle_pct = (k < RAND_SETTINGS / 3) ? 10 : (k < 2 * RAND_SETTINGS / 3) ? 69 : 0;
      n_src = pick_count();
      n_dst = pick_count();
      if (k == 0 || k == 2 * RAND_SETTINGS / 3) begin
        n_src = CNT_W'(MAX_SRC);
        n_dst = CNT_W'(MAX_DST);
      end
      set_counts(n_src, n_dst);
      set_gains(pick_lanes(1), pick_lanes(1), pick_lanes(1), pick_lanes(1));
      if ($urandom_range(3) == 0) reg_write(REG_SPARE_6, {$urandom, $urandom});
      for (int i = 0; i < RAND_FRAMES; i++) queue_frame(pick_lanes(0), pick_lanes(0));
      drain();
    end

    $display("Summary: %0d frames mixed over %0d channel/gain settings, %0d beats checked",
             frames_sent, settings_used, beats_checked);
    $display("Summary: %0d lanes clipped to the int16 range, %0d mismatches",
             clipped_lanes, mismatches);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
